/* hw/rtl/spc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the sphere pair collision block
// Word widths, micro-operation codes, controller states, the command and
// status bundles between controller and datapath, and small helper functions.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Field widths of one sphere record.
	localparam int W       = 32;          // position and velocity words
	localparam int RW      = W - 1;       // radius and mass
	localparam int DW      = W + 1;       // coordinate and velocity differences
	localparam int MW      = 64;          // multiplier operand width
	localparam int HW      = MW / 2;      // multiplier partial product operand
	localparam int PW      = 2 * MW;      // full product and dividend width
	localparam int RAD_W   = 2 * W + 4;   // squared distance and dot product sums
	localparam int DIST_W  = RAD_W / 2;   // integer square root
	localparam int DEN_W   = DIST_W + 1;  // divisor, covers twice the distance
	localparam int CFG_W   = 17;          // restitution register
	localparam int RES_FRAC = 16;         // restitution fraction bits

	// Restitution reset value and the unit term added to it.
	localparam logic [CFG_W-1:0] REST_RESET = CFG_W'(65536);
	localparam logic [CFG_W:0]   ONE_Q16    = (CFG_W+1)'(65536);

	localparam logic [1:0] LAST_AXIS = 2'd2;

	// Saturation bounds of an output word.
	localparam logic signed [MW-1:0] SAT_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - 64'sd1;

	// Micro-operations run by the datapath.
	typedef enum logic [3:0] {
		U_D2,    // accumulate squared distance, one axis
		U_RSQ,   // square of the radius sum
		U_RVD,   // accumulate relative velocity along the offset, one axis
		U_SQRT,  // center distance
		U_VN,    // closing speed
		U_T,     // closing speed times one plus restitution
		U_P1,    // t times second mass
		U_K1,    // first sphere impulse share
		U_P2,    // t times first mass
		U_K2,    // second sphere impulse share
		U_AM,    // k1 times offset
		U_AD,    // first sphere velocity change
		U_BM,    // k2 times offset
		U_BD,    // second sphere velocity change
		U_HM,    // penetration times offset
		U_HD     // position push
	} uop_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DECIDE,
		ST_OUT0,
		ST_OUT1
	} state_t;

	typedef enum logic [1:0] {
		STAT_APART      = 2'd0,
		STAT_SEPARATING = 2'd1,
		STAT_RESOLVED   = 2'd2,
		STAT_DEGENERATE = 2'd3
	} status_t;

	// Controller to datapath.
	typedef struct packed {
		logic       hold;     // store a first sphere request
		logic       capture;  // take a second sphere request and clear sums
		logic       start;    // launch the current micro-operation
		uop_t       uop;
		logic [1:0] axis;
		logic       out_sel;  // 0 first sphere, 1 second sphere on the output
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic done;   // micro-operation result written
		logic apart;  // squared distance not below squared radius sum
		logic degen;  // coincident centers or zero total mass
		logic sep;    // spheres are moving apart
	} sts_t;

	// Magnitude of a signed difference.
	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		mag = v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	// Clamp a wide signed value to one output word.
	function automatic logic [W-1:0] sat(input logic signed [MW-1:0] v);
		if (v > SAT_HI) begin
			sat = SAT_HI[W-1:0];
		end else if (v < SAT_LO) begin
			sat = SAT_LO[W-1:0];
		end else begin
			sat = v[W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/sphere_pair_collision_response_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_collision_response_top: sphere pair collision response
// Stream wrapper around the collision sequencer and its datapath.
// ----------------------------------------------------------------------------
// A request with tuser 0 stores the first sphere; a request with tuser 1 checks
// the second sphere against it and returns two records, first sphere then second
// (tlast on the second). Input is taken only while no pair is in work. A pair
// that is apart presents its first record after four multiplications and one
// decision state; touching pairs go on to the dot product, and a resolved
// collision goes on through the shared divider (twelve divisions), twelve
// multiplications and the square root. Each record then waits for
// m_axis_tready. The restitution register can be written at any time the block
// is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module sphere_pair_collision_response_top import spc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,        // restitution, Q1.16
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, mass, two zero bits
	input  logic [255:0]     s_axis_tdata,
	input  logic [0:0]       s_axis_tuser,    // slot
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
	output logic [6*W-1:0]   m_axis_tdata,
	output logic [2:0]       m_axis_tuser,    // sphere_id, status
	output logic             m_axis_tlast
);

	cmd_t          cmd;
	sts_t          sts;
	logic [W-1:0]  in_pos [3];
	logic [W-1:0]  in_vel [3];
	logic [W-1:0]  out_pos [3];
	logic [W-1:0]  out_vel [3];
	logic          out_id;
	logic [1:0]    out_status;

	// Unpack the request.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i] = s_axis_tdata[i*W +: W];
			in_vel[i] = s_axis_tdata[(i+3)*W +: W];
		end
	end

	assign cfg_ready = 1'b1;

	spc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_slot    (s_axis_tuser[0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_id     (out_id),
		.out_status (out_status),
		.out_last   (m_axis_tlast),
		.cmd        (cmd),
		.sts        (sts)
	);

	spc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid),
		.cfg_wdata (cfg_data),
		.in_pos    (in_pos),
		.in_vel    (in_vel),
		.in_radius (s_axis_tdata[6*W +: RW]),
		.in_mass   (s_axis_tdata[6*W+RW +: RW]),
		.out_pos   (out_pos),
		.out_vel   (out_vel)
	);

	// Pack the result record.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_axis_tdata[i*W +: W]     = out_pos[i];
			m_axis_tdata[(i+3)*W +: W] = out_vel[i];
		end
		m_axis_tuser = {out_status, out_id};
	end

endmodule

/* hw/rtl/spc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_mul: iterative unsigned multiplier
// Forms a 64 by 64 bit product from one 32 by 32 bit partial product a cycle.
// ----------------------------------------------------------------------------
module spc_mul import spc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] a,
	input  logic [MW-1:0] b,
	output logic [PW-1:0] prod,
	output logic          done
);

	logic [MW-1:0] a_q, b_q;
	logic [PW-1:0] prod_q;
	logic [1:0]    cnt_q;
	logic          busy_q, done_q;
	logic [HW-1:0] a_half, b_half;
	logic [MW-1:0] partial;
	logic [1:0]    shift;
	logic [PW-1:0] term;

	// Pick the halves for this cycle and align the partial product.
	always_comb begin
		a_half  = cnt_q[1] ? a_q[MW-1:HW] : a_q[HW-1:0];
		b_half  = cnt_q[0] ? b_q[MW-1:HW] : b_q[HW-1:0];
		partial = a_half * b_half;
		shift   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		term    = PW'(partial) << (shift * HW);
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and the running sum.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_q + term;
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

/* hw/rtl/spc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_div: restoring divider, two quotient bits a cycle
// Divides a 128-bit dividend by a divisor of up to 35 bits; the quotient
// shifts into the dividend register as the dividend shifts out.
// ----------------------------------------------------------------------------
module spc_div import spc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PW-1:0]    num,
	input  logic [DEN_W-1:0] den,
	output logic [PW-1:0]    quo,
	output logic             done
);

	localparam int STEPS = PW / 2;
	localparam int CW    = $clog2(STEPS);

	logic [PW-1:0]    num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   r1, r2;
	logic [DEN_W-1:0] rem1, rem2;
	logic             q1, q2;

	// Two dependent compare and subtract steps.
	always_comb begin
		r1   = {rem_q, num_q[PW-1]};
		q1   = (r1 >= {1'b0, den_q});
		rem1 = q1 ? DEN_W'(r1 - {1'b0, den_q}) : r1[DEN_W-1:0];
		r2   = {rem1, num_q[PW-2]};
		q2   = (r2 >= {1'b0, den_q});
		rem2 = q2 ? DEN_W'(r2 - {1'b0, den_q}) : r2[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PW-3:0], q1, q2};
			rem_q <= rem2;
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule

/* hw/rtl/spc_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_sqrt: digit-by-digit integer square root
// Takes two radicand bits a cycle and settles one root bit a cycle.
// ----------------------------------------------------------------------------
module spc_sqrt import spc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic [DIST_W-1:0] root,
	output logic              done
);

	localparam int CW  = $clog2(DIST_W);
	localparam int REM = DIST_W + 3;

	logic [RAD_W-1:0]  rad_q;
	logic [DIST_W-1:0] root_q;
	logic [REM-1:0]    rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [REM-1:0]    r, trial;
	logic              ge;

	// Trial subtraction of the doubled root with a one appended.
	always_comb begin
		r     = {rem_q[REM-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial = {1'b0, root_q, 2'b01};
		ge    = (r >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIST_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[DIST_W-2:0], ge};
			rem_q  <= ge ? (r - trial) : r;
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

/* hw/rtl/spc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_datapath: sphere records, arithmetic units and result registers
// Holds the first sphere, the second sphere and the working values, feeds the
// shared multiplier, divider and square root, and writes each result back.
// ----------------------------------------------------------------------------
module spc_datapath import spc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output sts_t          sts,
	input  logic          cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic [W-1:0]  in_pos [3],
	input  logic [W-1:0]  in_vel [3],
	input  logic [RW-1:0] in_radius,
	input  logic [RW-1:0] in_mass,
	output logic [W-1:0]  out_pos [3],
	output logic [W-1:0]  out_vel [3]
);

	// Held first sphere and restitution.
	logic [W-1:0]     hp_q [3];
	logic [W-1:0]     hv_q [3];
	logic [RW-1:0]    hr_q, hm_q;
	logic [CFG_W-1:0] rest_q;

	// Second sphere.
	logic [W-1:0]  ip_q [3];
	logic [W-1:0]  iv_q [3];
	logic [RW-1:0] ir_q, im_q;

	// Working values.
	logic [RAD_W-1:0]  dist2_q, pos_q, neg_q;
	logic [2*W-1:0]    rsq_q;
	logic [DIST_W-1:0] dist_q;
	logic [MW-1:0]     vn_q, t_q, k1_q, k2_q;

	// Results, wide two's complement until the output clamp.
	logic signed [MW-1:0] p1_q [3];
	logic signed [MW-1:0] v1_q [3];
	logic signed [MW-1:0] p2_q [3];
	logic signed [MW-1:0] v2_q [3];

	logic signed [DW-1:0] d_ax, rv_ax;
	logic [DW-1:0]        ad_ax, arv_ax;
	logic                 s_ax;
	logic [W-1:0]         sum_r, tot_m, pen;
	logic [MW-1:0]        mul_a, mul_b;
	logic [PW-1:0]        div_num;
	logic [DEN_W-1:0]     div_den;
	logic                 is_mul, is_div, is_sqrt;
	logic [PW-1:0]        mul_prod, div_quo;
	logic [DIST_W-1:0]    sqrt_root;
	logic                 mul_done, div_done, sqrt_done;
	logic [MW-1:0]        q64;

	// Per-axis offsets, sums and the operand selection.
	always_comb begin
		d_ax   = $signed({ip_q[cmd.axis][W-1], ip_q[cmd.axis]})
		       - $signed({hp_q[cmd.axis][W-1], hp_q[cmd.axis]});
		rv_ax  = $signed({iv_q[cmd.axis][W-1], iv_q[cmd.axis]})
		       - $signed({hv_q[cmd.axis][W-1], hv_q[cmd.axis]});
		ad_ax  = mag(d_ax);
		arv_ax = mag(rv_ax);
		s_ax   = d_ax[DW-1];
		sum_r  = {1'b0, hr_q} + {1'b0, ir_q};
		tot_m  = {1'b0, hm_q} + {1'b0, im_q};
		pen    = sum_r - dist_q[W-1:0];
		q64    = div_quo[MW-1:0];

		is_mul  = 1'b0;
		is_div  = 1'b0;
		is_sqrt = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_num = mul_prod;
		div_den = DEN_W'(dist_q);
		case (cmd.uop)
			U_D2: begin
				is_mul = 1'b1;
				mul_a  = MW'(ad_ax);
				mul_b  = MW'(ad_ax);
			end
			U_RSQ: begin
				is_mul = 1'b1;
				mul_a  = MW'(sum_r);
				mul_b  = MW'(sum_r);
			end
			U_RVD: begin
				is_mul = 1'b1;
				mul_a  = MW'(arv_ax);
				mul_b  = MW'(ad_ax);
			end
			U_SQRT: is_sqrt = 1'b1;
			U_VN: begin
				is_div  = 1'b1;
				div_num = PW'(RAD_W'(neg_q - pos_q));
			end
			U_T: begin
				is_mul = 1'b1;
				mul_a  = MW'(ONE_Q16 + (CFG_W+1)'(rest_q));
				mul_b  = vn_q;
			end
			U_P1: begin
				is_mul = 1'b1;
				mul_a  = t_q;
				mul_b  = MW'(im_q);
			end
			U_P2: begin
				is_mul = 1'b1;
				mul_a  = t_q;
				mul_b  = MW'(hm_q);
			end
			U_K1, U_K2: begin
				is_div  = 1'b1;
				div_den = DEN_W'(tot_m);
			end
			U_AM: begin
				is_mul = 1'b1;
				mul_a  = k1_q;
				mul_b  = MW'(ad_ax);
			end
			U_BM: begin
				is_mul = 1'b1;
				mul_a  = k2_q;
				mul_b  = MW'(ad_ax);
			end
			U_HM: begin
				is_mul = 1'b1;
				mul_a  = MW'(pen);
				mul_b  = MW'(ad_ax);
			end
			U_AD, U_BD: is_div = 1'b1;
			U_HD: begin
				is_div  = 1'b1;
				div_den = {dist_q, 1'b0};
			end
			default: ;
		endcase
	end

	spc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start & is_mul),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	spc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start & is_div),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	spc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start & is_sqrt),
		.rad    (dist2_q),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	// Held first sphere and the restitution register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				hp_q[i] <= '0;
				hv_q[i] <= '0;
			end
			hr_q   <= '0;
			hm_q   <= '0;
			rest_q <= REST_RESET;
		end else begin
			if (cmd.hold) begin
				for (int i = 0; i < 3; i++) begin
					hp_q[i] <= in_pos[i];
					hv_q[i] <= in_vel[i];
				end
				hr_q <= in_radius;
				hm_q <= in_mass;
			end
			if (cfg_we) begin
				rest_q <= cfg_wdata;
			end
		end
	end

	// Second sphere capture and result write-back.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < 3; i++) begin
				ip_q[i] <= in_pos[i];
				iv_q[i] <= in_vel[i];
				p1_q[i] <= {{(MW-W){hp_q[i][W-1]}}, hp_q[i]};
				v1_q[i] <= {{(MW-W){hv_q[i][W-1]}}, hv_q[i]};
				p2_q[i] <= {{(MW-W){in_pos[i][W-1]}}, in_pos[i]};
				v2_q[i] <= {{(MW-W){in_vel[i][W-1]}}, in_vel[i]};
			end
			ir_q    <= in_radius;
			im_q    <= in_mass;
			dist2_q <= '0;
			pos_q   <= '0;
			neg_q   <= '0;
		end else if (sts.done) begin
			case (cmd.uop)
				U_D2:   dist2_q <= dist2_q + RAD_W'(mul_prod);
				U_RSQ:  rsq_q <= mul_prod[2*W-1:0];
				U_RVD: begin
					if (rv_ax[DW-1] == s_ax) begin
						pos_q <= pos_q + RAD_W'(mul_prod);
					end else begin
						neg_q <= neg_q + RAD_W'(mul_prod);
					end
				end
				U_SQRT: dist_q <= sqrt_root;
				U_VN:   vn_q <= q64;
				U_T:    t_q <= mul_prod[MW+RES_FRAC-1:RES_FRAC];
				U_K1:   k1_q <= q64;
				U_K2:   k2_q <= q64;
				U_AD: begin
					v1_q[cmd.axis] <= s_ax ? v1_q[cmd.axis] + $signed(q64)
					                       : v1_q[cmd.axis] - $signed(q64);
				end
				U_BD: begin
					v2_q[cmd.axis] <= s_ax ? v2_q[cmd.axis] - $signed(q64)
					                       : v2_q[cmd.axis] + $signed(q64);
				end
				U_HD: begin
					p1_q[cmd.axis] <= s_ax ? p1_q[cmd.axis] + $signed(q64)
					                       : p1_q[cmd.axis] - $signed(q64);
					p2_q[cmd.axis] <= s_ax ? p2_q[cmd.axis] - $signed(q64)
					                       : p2_q[cmd.axis] + $signed(q64);
				end
				default: ;
			endcase
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.done  = mul_done | div_done | sqrt_done;
		sts.apart = !(dist2_q < RAD_W'(rsq_q));
		sts.degen = (dist2_q == '0) || (tot_m == '0);
		sts.sep   = (neg_q < pos_q);
	end

	// Clamped output record.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_pos[i] = cmd.out_sel ? sat(p2_q[i]) : sat(p1_q[i]);
			out_vel[i] = cmd.out_sel ? sat(v2_q[i]) : sat(v1_q[i]);
		end
	end

endmodule

/* hw/rtl/spc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_ctrl: sequencer of the collision check
// Steps through the micro-operations, takes the early exits and hands out the
// two result records.
// ----------------------------------------------------------------------------
module spc_ctrl import spc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_slot,
	output logic out_valid,
	input  logic out_ready,
	output logic out_id,
	output logic [1:0] out_status,
	output logic out_last,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t     state_q, state_d;
	uop_t       uop_q, uop_d;
	logic [1:0] axis_q, axis_d;
	status_t    status_q, status_d;
	logic       in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			uop_q    <= U_D2;
			axis_q   <= '0;
			status_q <= STAT_APART;
		end else begin
			state_q  <= state_d;
			uop_q    <= uop_d;
			axis_q   <= axis_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		uop_d    = uop_q;
		axis_d   = axis_q;
		status_d = status_q;
		in_acc   = in_valid && (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_slot) begin
					uop_d   = U_D2;
					axis_d  = '0;
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (sts.done) begin
					state_d = ST_ISSUE;
					case (uop_q)
						U_D2: begin
							if (axis_q == LAST_AXIS) begin
								uop_d  = U_RSQ;
								axis_d = '0;
							end else begin
								axis_d = axis_q + 2'd1;
							end
						end
						U_RSQ: state_d = ST_DECIDE;
						U_RVD: begin
							if (axis_q == LAST_AXIS) begin
								state_d = ST_DECIDE;
							end else begin
								axis_d = axis_q + 2'd1;
							end
						end
						U_SQRT: uop_d = U_VN;
						U_VN:   uop_d = U_T;
						U_T:    uop_d = U_P1;
						U_P1:   uop_d = U_K1;
						U_K1:   uop_d = U_P2;
						U_P2:   uop_d = U_K2;
						U_K2: begin
							uop_d  = U_AM;
							axis_d = '0;
						end
						U_AM: uop_d = U_AD;
						U_AD: uop_d = U_BM;
						U_BM: uop_d = U_BD;
						U_BD: uop_d = U_HM;
						U_HM: uop_d = U_HD;
						U_HD: begin
							if (axis_q == LAST_AXIS) begin
								status_d = STAT_RESOLVED;
								state_d  = ST_OUT0;
							end else begin
								uop_d  = U_AM;
								axis_d = axis_q + 2'd1;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DECIDE: begin
				if (uop_q == U_RSQ) begin
					if (sts.apart) begin
						status_d = STAT_APART;
						state_d  = ST_OUT0;
					end else if (sts.degen) begin
						status_d = STAT_DEGENERATE;
						state_d  = ST_OUT0;
					end else begin
						uop_d   = U_RVD;
						axis_d  = '0;
						state_d = ST_ISSUE;
					end
				end else if (sts.sep) begin
					status_d = STAT_SEPARATING;
					state_d  = ST_OUT0;
				end else begin
					uop_d   = U_SQRT;
					state_d = ST_ISSUE;
				end
			end
			ST_OUT0: begin
				if (out_ready) begin
					state_d = ST_OUT1;
				end
			end
			ST_OUT1: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshakes and datapath commands.
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		out_id      = (state_q == ST_OUT1);
		out_last    = (state_q == ST_OUT1);
		out_status  = status_q;
		cmd.hold    = in_acc && !in_slot;
		cmd.capture = in_acc && in_slot;
		cmd.start   = (state_q == ST_ISSUE);
		cmd.uop     = uop_q;
		cmd.axis    = axis_q;
		cmd.out_sel = (state_q == ST_OUT1);
	end

endmodule
